### src/i2p_pkg.sv
// Shared definitions for the infix to postfix converter: token and result
// codes, error codes and the command and status bundles between controller
// and datapath. No dependencies.
package i2p_pkg;

   // Default sizing, used by the top level's parameters.
   localparam int STACK_DEPTH_DEF = 16;
   localparam int VALUE_BITS_DEF  = 32;

   // Token kinds on the request side.
   localparam logic [3:0] TOK_NUMBER = 4'd0;
   localparam logic [3:0] TOK_OPEN   = 4'd1;
   localparam logic [3:0] TOK_CLOSE  = 4'd2;
   localparam logic [3:0] TOK_PLUS   = 4'd3;
   localparam logic [3:0] TOK_MINUS  = 4'd4;
   localparam logic [3:0] TOK_TIMES  = 4'd5;
   localparam logic [3:0] TOK_DIVIDE = 4'd6;
   localparam logic [3:0] TOK_MODULO = 4'd7;
   localparam logic [3:0] TOK_BANG   = 4'd8;
   localparam logic [3:0] TOK_TILDE  = 4'd9;
   localparam logic [3:0] TOK_CARET  = 4'd10;
   localparam logic [3:0] TOK_END    = 4'd11;

   // Result kinds. An operator's result kind is its token code less this offset.
   localparam logic [3:0] KIND_NUMBER = 4'd0;
   localparam logic [3:0] KIND_END    = 4'd9;
   localparam logic [3:0] KIND_OFFSET = 4'd2;

   // Error codes carried on each result.
   localparam logic [1:0] ERR_OK          = 2'd0;
   localparam logic [1:0] ERR_OPEN_CLOSE  = 2'd1;
   localparam logic [1:0] ERR_OPEN_LEFT   = 2'd2;
   localparam logic [1:0] ERR_OVERFLOW    = 2'd3;

   // Source of the next result loaded into the output register.
   typedef enum logic [1:0] {
      SEL_NONE = 2'd0,
      SEL_HOLD = 2'd1,
      SEL_NEW  = 2'd2
   } out_sel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic        load;       // capture the accepted request
      logic        push;       // push the token onto the operator stack
      logic        pop;        // drop the top of the operator stack
      logic        hold_load;  // park a popped operator in the hold register
      out_sel_type out_sel;    // what goes to the output register
      logic        out_last;   // last flag of that result
      logic [3:0]  res_kind;   // kind of a new result
      logic [1:0]  res_err;    // error code of a new result
      logic        res_num;    // a new result carries the token's value
   } ctrl_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [3:0] tok_cmd;     // kind of the captured token
      logic [3:0] top;         // top of the operator stack
      logic       empty;
      logic       full;
      logic       hold_valid;  // a popped operator waits in the hold register
      logic       out_free;    // output register can take a result this cycle
   } dp_status_type;

endpackage

### src/i2p_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module i2p_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 16,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/i2p_dpath.sv
// Datapath of the infix to postfix converter: token capture, operator stack
// (count plus RAM), hold register for popped operators and output register.
// Depends on i2p_pkg and i2p_ram.
module i2p_dpath #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_BITS  = i2p_pkg::VALUE_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [3:0]             tok_cmd,
   input  logic [VALUE_BITS-1:0]  tok_value,
   input  i2p_pkg::ctrl_cmd_type  ctl,
   output i2p_pkg::dp_status_type st,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [3:0]             rsp_kind,
   output logic [VALUE_BITS-1:0]  rsp_value,
   output logic [1:0]             rsp_err,
   output logic                   rsp_last
);

   import i2p_pkg::*;

   localparam int CNT_BITS  = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_BITS = $clog2(STACK_DEPTH);

   logic [3:0]            cmd_ff;
   logic [VALUE_BITS-1:0] value_ff;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic                  hold_valid_ff, hold_valid_in;
   logic [3:0]            hold_kind_ff;
   logic                  out_valid_ff, out_valid_in;
   logic [3:0]            out_kind_ff;
   logic [VALUE_BITS-1:0] out_value_ff;
   logic [1:0]            out_err_ff;
   logic                  out_last_ff;
   logic                  empty, full, out_free;
   logic [ADDR_BITS-1:0]  rd_addr;
   logic [3:0]            top;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CNT_BITS'(STACK_DEPTH));
   assign out_free = !out_valid_ff || rsp_ready;

   // The read address follows the stack pointer; the RAM registers the read data.
   assign rd_addr = empty ? '0 : ADDR_BITS'(count_ff - 1'b1);

   i2p_ram #(
      .WIDTH(4),
      .DEPTH(STACK_DEPTH)
   ) u_stack (
      .clock  (clock),
      .wr_en  (ctl.push),
      .wr_addr(count_ff[ADDR_BITS-1:0]),
      .wr_data(cmd_ff),
      .rd_addr(rd_addr),
      .rd_data(top)
   );

   // Captured token.
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff   <= tok_cmd;
         value_ff <= tok_value;
      end
   end

   // Stack pointer.
   always_comb begin
      count_in = count_ff;
      if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Hold register: a popped operator waits here until it is known whether
   // it ends the request's results.
   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (ctl.hold_load) begin
         hold_valid_in = 1'b1;
      end else if (ctl.out_sel == SEL_HOLD) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.hold_load) begin
         hold_kind_ff <= top - KIND_OFFSET;
      end
   end

   // Output register valid.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (ctl.out_sel != SEL_NONE) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   // Output register payload.
   always_ff @(posedge clock) begin
      unique case (ctl.out_sel)
         SEL_HOLD: begin
            out_kind_ff  <= hold_kind_ff;
            out_value_ff <= '0;
            out_err_ff   <= ERR_OK;
            out_last_ff  <= ctl.out_last;
         end
         SEL_NEW: begin
            out_kind_ff  <= ctl.res_kind;
            out_value_ff <= ctl.res_num ? value_ff : '0;
            out_err_ff   <= ctl.res_err;
            out_last_ff  <= ctl.out_last;
         end
         default: begin
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         hold_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         hold_valid_ff <= hold_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign st.tok_cmd    = cmd_ff;
   assign st.top        = top;
   assign st.empty      = empty;
   assign st.full       = full;
   assign st.hold_valid = hold_valid_ff;
   assign st.out_free   = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_kind  = out_kind_ff;
   assign rsp_value = out_value_ff;
   assign rsp_err   = out_err_ff;
   assign rsp_last  = out_last_ff;

endmodule

### src/i2p_ctrl.sv
// Controller of the infix to postfix converter: accepts a request, waits for
// the top of the stack and sequences pops, pushes and results one per step.
// Depends on i2p_pkg.
module i2p_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  i2p_pkg::dp_status_type st,
   output i2p_pkg::ctrl_cmd_type  ctl
);

   import i2p_pkg::*;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_LOOK = 2'd1;
   localparam logic [1:0] S_EVAL = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       open_left_ff, open_left_in;

   // Decision for the current step.
   logic       pop_emit;   // emit the top operator and pop it, then look again
   logic       term_emit;  // emit a result that ends the request
   logic       drop_open;  // discard an open parenthesis during the flush
   logic       do_push;
   logic       do_pop;
   logic [3:0] res_kind;
   logic [1:0] res_err;
   logic       res_num;
   logic       pop_prec;

   // Whether the top of the stack leaves before an operator of this kind.
   always_comb begin
      if (st.tok_cmd <= TOK_MINUS) begin
         pop_prec = (st.top != TOK_OPEN);
      end else if (st.tok_cmd <= TOK_MODULO) begin
         pop_prec = (st.top >= TOK_TIMES) && (st.top <= TOK_CARET);
      end else begin
         pop_prec = (st.top >= TOK_BANG) && (st.top <= TOK_CARET);
      end
   end

   // Classify the step from the token and the top of the stack.
   always_comb begin
      pop_emit  = 1'b0;
      term_emit = 1'b0;
      drop_open = 1'b0;
      do_push   = 1'b0;
      do_pop    = 1'b0;
      res_kind  = KIND_NUMBER;
      res_err   = ERR_OK;
      res_num   = 1'b0;
      unique case (st.tok_cmd)
         TOK_NUMBER: begin
            term_emit = 1'b1;
            res_num   = 1'b1;
         end
         TOK_OPEN: begin
            if (st.full) begin
               term_emit = 1'b1;
               res_err   = ERR_OVERFLOW;
            end else begin
               do_push = 1'b1;
            end
         end
         TOK_CLOSE: begin
            if (st.empty) begin
               term_emit = 1'b1;
               res_err   = ERR_OPEN_CLOSE;
            end else if (st.top == TOK_OPEN) begin
               do_pop = 1'b1;
            end else begin
               pop_emit = 1'b1;
            end
         end
         TOK_PLUS, TOK_MINUS, TOK_TIMES, TOK_DIVIDE, TOK_MODULO,
         TOK_BANG, TOK_TILDE, TOK_CARET: begin
            if (!st.empty && pop_prec) begin
               pop_emit = 1'b1;
            end else if (st.full) begin
               term_emit = 1'b1;
               res_err   = ERR_OVERFLOW;
            end else begin
               do_push = 1'b1;
            end
         end
         TOK_END: begin
            if (st.empty) begin
               term_emit = 1'b1;
               res_kind  = KIND_END;
               res_err   = open_left_ff ? ERR_OPEN_LEFT : ERR_OK;
            end else if (st.top == TOK_OPEN) begin
               drop_open = 1'b1;
            end else begin
               pop_emit = 1'b1;
            end
         end
         default: begin
            // Unknown token kinds leave no trace.
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      open_left_in = open_left_ff;
      req_ready    = 1'b0;
      ctl          = '0;
      ctl.out_sel  = SEL_NONE;
      ctl.res_kind = res_kind;
      ctl.res_err  = res_err;
      ctl.res_num  = res_num;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               ctl.load     = 1'b1;
               open_left_in = 1'b0;
               state_in     = S_LOOK;
            end
         end
         S_LOOK: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            if (pop_emit) begin
               // The parked operator, if any, is known not to be last now.
               if (!st.hold_valid || st.out_free) begin
                  ctl.out_sel   = st.hold_valid ? SEL_HOLD : SEL_NONE;
                  ctl.hold_load = 1'b1;
                  ctl.pop       = 1'b1;
                  state_in      = S_LOOK;
               end
            end else if (drop_open) begin
               ctl.pop      = 1'b1;
               open_left_in = 1'b1;
               state_in     = S_LOOK;
            end else if (term_emit) begin
               // Release a parked operator first, then the final result.
               if (st.out_free) begin
                  if (st.hold_valid) begin
                     ctl.out_sel = SEL_HOLD;
                  end else begin
                     ctl.out_sel  = SEL_NEW;
                     ctl.out_last = 1'b1;
                     state_in     = S_IDLE;
                  end
               end
            end else begin
               // No result of its own: a parked operator becomes the last one.
               if (!st.hold_valid || st.out_free) begin
                  if (st.hold_valid) begin
                     ctl.out_sel  = SEL_HOLD;
                     ctl.out_last = 1'b1;
                  end
                  ctl.push = do_push;
                  ctl.pop  = do_pop;
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         open_left_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         open_left_ff <= open_left_in;
      end
   end

endmodule

### src/infix_to_postfix_converter.sv
// Top level of the infix to postfix converter (shunting-yard over classified
// tokens). Depends on i2p_pkg, i2p_ctrl, i2p_dpath and i2p_ram.
//
//  Channel  Dir  Handshake            Payload
//  req_     in   req_tvalid/tready    tuser: token kind; tdata: number value
//  rsp_     out  rsp_tvalid/tready    tuser: result kind; tdata: value, error;
//                                     tlast: final result of a request
//
// A request is taken in idle, then waits in look for the stack RAM's
// registered read and is decided in evaluate; each operator popped and each
// open parenthesis dropped by an end token repeats look and evaluate, and an
// extra evaluate step releases a popped operator that meets a final result.
// Reset is synchronous and active high; the stack contents need no clearing.
// A stalled result port holds the sequencer only when a result must move;
// a new request is taken while the last result still waits in its register.
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF,
   parameter int VALUE_BITS  = i2p_pkg::VALUE_BITS_DEF,
   localparam int REQ_BITS   = ((VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_BITS   = ((VALUE_BITS + 2 + 7) / 8) * 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_BITS-1:0] req_tdata,   // number_value
   input  logic [3:0]          req_tuser,   // cmd
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_BITS-1:0] rsp_tdata,   // out_value, error_code
   output logic [3:0]          rsp_tuser,   // out_kind
   output logic                rsp_tlast    // last
);

   import i2p_pkg::*;

   ctrl_cmd_type          ctl;
   dp_status_type         st;
   logic [VALUE_BITS-1:0] rsp_value;
   logic [1:0]            rsp_err;

   i2p_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .st       (st),
      .ctl      (ctl)
   );

   i2p_dpath #(
      .STACK_DEPTH(STACK_DEPTH),
      .VALUE_BITS (VALUE_BITS)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .tok_cmd  (req_tuser),
      .tok_value(req_tdata[VALUE_BITS-1:0]),
      .ctl      (ctl),
      .st       (st),
      .rsp_valid(rsp_tvalid),
      .rsp_ready(rsp_tready),
      .rsp_kind (rsp_tuser),
      .rsp_value(rsp_value),
      .rsp_err  (rsp_err),
      .rsp_last (rsp_tlast)
   );

   // Pack the result payload, value in the low bits, zero filled to bytes.
   assign rsp_tdata = RSP_BITS'({rsp_err, rsp_value});

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps
// Self-checking bench for infix_to_postfix_converter: directed token sequences, then
// random expressions under changing stream back-pressure, checked against a predictor.
// Depends on i2p_pkg and the converter RTL only.
module testbench;
   import i2p_pkg::*;

   localparam int VALUE_W       = VALUE_BITS_DEF;
   localparam int DEPTH         = STACK_DEPTH_DEF;
   localparam int REQ_W         = ((VALUE_W + 7) / 8) * 8;
   localparam int RSP_W         = ((VALUE_W + 2 + 7) / 8) * 8;
   localparam int IDLE_LIMIT    = 2000;
   localparam int HOLD_CYCLES   = 300;
   localparam int SETTLE_CYCLES = 100;

   // One postfix token as it should appear on the result stream.
   typedef struct packed {
      logic [3:0]         kind;
      logic [VALUE_W-1:0] value;
      logic [1:0]         err;
      logic               last;
   } postfix_token_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic [3:0]       req_tuser  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic [3:0]       rsp_tuser;
   logic             rsp_tlast;

   // Predictor state: its own operator stack and the tokens still to arrive.
   logic [3:0]        op_stack [DEPTH];
   int unsigned       op_depth = 0;
   postfix_token_type step_out [$];
   postfix_token_type postfix_expected [$];

   int unsigned failures       = 0;
   int unsigned tokens_sent    = 0;
   int unsigned results_seen   = 0;
   int unsigned idle_cycles    = 0;
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned hold_starts    = 0;
   int unsigned hold_seen      = 0;
   int unsigned hold_left      = 0;

   infix_to_postfix_converter #(
      .STACK_DEPTH(DEPTH),
      .VALUE_BITS (VALUE_W)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always #10 clock = ~clock;

   // Append one predicted token for the current request.
   function automatic void emit_token(logic [3:0] kind, logic [VALUE_W-1:0] value,
                                      logic [1:0] err);
      postfix_token_type t;
      t.kind   = kind;
      t.value  = value;
      t.err    = err;
      t.last   = 1'b0;
      step_out = {step_out, t};
   endfunction

   function automatic void pop_operator();
      op_depth--;
      emit_token(op_stack[op_depth] - KIND_OFFSET, '0, ERR_OK);
   endfunction

   // True when the operator on top must leave the stack before the incoming one.
   function automatic bit outranks(logic [3:0] incoming, logic [3:0] top);
      if (incoming <= TOK_MINUS) return top != TOK_OPEN;
      if (incoming <= TOK_MODULO) return top >= TOK_TIMES && top <= TOK_CARET;
      return top >= TOK_BANG && top <= TOK_CARET;
   endfunction

   // Shunting-yard step: work out every postfix token one request produces.
   function automatic void convert_token(logic [3:0] cmd, logic [VALUE_W-1:0] value);
      bit open_left;
      step_out.delete();
      open_left = 1'b0;
      if (cmd == TOK_NUMBER) begin
         emit_token(KIND_NUMBER, value, ERR_OK);
      end else if (cmd == TOK_OPEN) begin
         if (op_depth >= DEPTH) begin
            emit_token(KIND_NUMBER, '0, ERR_OVERFLOW);
         end else begin
            op_stack[op_depth] = TOK_OPEN;
            op_depth++;
         end
      end else if (cmd == TOK_CLOSE) begin
         while (op_depth > 0 && op_stack[op_depth-1] != TOK_OPEN) pop_operator();
         if (op_depth > 0) op_depth--;
         else emit_token(KIND_NUMBER, '0, ERR_OPEN_CLOSE);
      end else if (cmd >= TOK_PLUS && cmd <= TOK_CARET) begin
         while (op_depth > 0 && outranks(cmd, op_stack[op_depth-1])) pop_operator();
         if (op_depth >= DEPTH) begin
            emit_token(KIND_NUMBER, '0, ERR_OVERFLOW);
         end else begin
            op_stack[op_depth] = cmd;
            op_depth++;
         end
      end else if (cmd == TOK_END) begin
         // Open parentheses still on the stack are dropped and flagged on the marker.
         while (op_depth > 0) begin
            if (op_stack[op_depth-1] == TOK_OPEN) begin
               op_depth--;
               open_left = 1'b1;
            end else begin
               pop_operator();
            end
         end
         emit_token(KIND_END, '0, open_left ? ERR_OPEN_LEFT : ERR_OK);
      end
      if (step_out.size() > 0) step_out[step_out.size()-1].last = 1'b1;
      foreach (step_out[i]) postfix_expected = {postfix_expected, step_out[i]};
   endfunction

   task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
      $display("%0t: result %0d, %s: got 0x%0h, expected 0x%0h",
               $time, results_seen, field, got, want);
      failures++;
   endtask

   // Compare an accepted result with the oldest predicted token.
   task automatic check_result();
      postfix_token_type want;
      results_seen++;
      if (postfix_expected.size() == 0) begin
         report_mismatch("unexpected result kind", rsp_tuser, '0);
         return;
      end
      want = postfix_expected.pop_front();
      if (rsp_tuser !== want.kind) report_mismatch("out_kind", rsp_tuser, want.kind);
      if (rsp_tdata[VALUE_W-1:0] !== want.value)
         report_mismatch("out_value", rsp_tdata[VALUE_W-1:0], want.value);
      if (rsp_tdata[VALUE_W+1:VALUE_W] !== want.err)
         report_mismatch("error_code", rsp_tdata[VALUE_W+1:VALUE_W], want.err);
      if (rsp_tlast !== want.last) report_mismatch("last", rsp_tlast, want.last);
      if (rsp_tdata[RSP_W-1:VALUE_W+2] !== '0)
         report_mismatch("tdata padding", rsp_tdata[RSP_W-1:VALUE_W+2], '0);
   endtask

   // Result side: check each accepted result, then choose tready for the next cycle.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left  <= hold_left - 1;
         end else if (hold_starts != hold_seen) begin
            hold_seen  <= hold_starts;
            hold_left  <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Watchdog on cycles in which neither channel moves anything.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Timeout: no request or result accepted for %0d cycles", IDLE_LIMIT);
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one token, with random idle cycles first, and predict once it is taken.
   task automatic send_token(logic [3:0] cmd, logic [VALUE_W-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_W'(value);
      do @(posedge clock); while (!req_tready);
      convert_token(cmd, value);
      if (cmd <= TOK_END) tokens_sent++;
   endtask

   function automatic logic [VALUE_W-1:0] random_value();
      case ($urandom_range(9))
         0: return '0;
         1: return '1;
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   // Random expressions: mostly well formed, with stray tokens and early ends mixed in.
   task automatic random_expressions(int unsigned goal);
      int unsigned target;
      int unsigned depth;
      int unsigned max_depth;
      int unsigned open_pct;
      int unsigned terms_left;
      bit          deep;
      bit          need_operand;
      bit          done;
      target = tokens_sent + goal;
      while (tokens_sent < target) begin
         // A few deeply nested expressions drive the stack into overflow.
         deep         = ($urandom_range(99) < 12);
         max_depth    = deep ? DEPTH + 3 : $urandom_range(0, 4);
         open_pct     = deep ? 95 : 30;
         terms_left   = $urandom_range(1, 10);
         depth        = 0;
         need_operand = 1'b1;
         done         = 1'b0;
         while (!done) begin
            if ($urandom_range(99) < 6) begin
               send_token(4'($urandom_range(0, 15)), VALUE_W'($urandom));
            end else if (need_operand) begin
               if (depth < max_depth && $urandom_range(99) < open_pct) begin
                  send_token(TOK_OPEN, VALUE_W'($urandom));
                  depth++;
               end else begin
                  send_token(TOK_NUMBER, random_value());
                  need_operand = 1'b0;
                  if (terms_left > 0) terms_left--;
               end
            end else if ($urandom_range(99) < 3) begin
               done = 1'b1;
            end else if (depth > 0 && ($urandom_range(99) < 35 || terms_left == 0)) begin
               send_token(TOK_CLOSE, VALUE_W'($urandom));
               depth--;
            end else if (terms_left > 0) begin
               send_token(4'($urandom_range(TOK_PLUS, TOK_CARET)), VALUE_W'($urandom));
               need_operand = 1'b1;
            end else begin
               done = 1'b1;
            end
         end
         send_token(TOK_END, VALUE_W'($urandom));
      end
   endtask

   // Every operator with its precedence, and the extreme number values.
   task automatic test_operator_precedence();
      send_token(TOK_NUMBER, '1);
      send_token(TOK_MINUS,  '0);
      send_token(TOK_NUMBER, '0);
      send_token(TOK_DIVIDE, '0);
      send_token(TOK_NUMBER, 32'h0000_0001);
      send_token(TOK_MODULO, '0);
      send_token(TOK_NUMBER, 32'h8000_0000);
      send_token(TOK_CARET,  '0);
      send_token(TOK_NUMBER, 32'h0000_0003);
      send_token(TOK_TILDE,  '0);
      send_token(TOK_NUMBER, 32'h5555_5555);
      send_token(TOK_BANG,   '0);
      send_token(TOK_NUMBER, 32'hAAAA_AAAA);
      send_token(TOK_TIMES,  '1);
      send_token(TOK_NUMBER, 32'h7FFF_FFFF);
      send_token(TOK_PLUS,   '1);
      send_token(TOK_NUMBER, 32'h0000_0007);
      send_token(TOK_END,    '0);
   endtask

   // Unmatched close parenthesis, leftover open parenthesis and unknown token kinds.
   task automatic test_parenthesis_errors();
      send_token(TOK_CLOSE,  '0);
      send_token(TOK_NUMBER, 32'h0000_0005);
      send_token(TOK_PLUS,   '0);
      send_token(TOK_NUMBER, 32'h0000_0009);
      send_token(TOK_CLOSE,  '0);
      for (int k = TOK_END + 1; k <= 15; k++) send_token(4'(k), '1);
      send_token(TOK_OPEN,   '0);
      send_token(TOK_NUMBER, 32'h0000_0002);
      send_token(TOK_END,    '0);
      send_token(TOK_END,    '0);
   endtask

   // Fill the stack, then overflow it with an operator and with an open parenthesis.
   task automatic test_stack_overflow();
      for (int k = 0; k < DEPTH - 1; k++) send_token(TOK_OPEN, '0);
      send_token(TOK_PLUS,  '0);
      send_token(TOK_TIMES, '0);
      send_token(TOK_OPEN,  '0);
      send_token(TOK_CLOSE, '0);
      send_token(TOK_END,   '0);
   endtask

   // Random expressions through each mix of sender idling and receiver stalls.
   task automatic test_random_streams();
      send_idle_pct = 0;  recv_stall_pct = 0;  random_expressions(75);
      send_idle_pct = 46; recv_stall_pct = 0;  random_expressions(75);
      send_idle_pct = 0;  recv_stall_pct = 46; random_expressions(75);
      send_idle_pct = 26; recv_stall_pct = 26; random_expressions(75);
   endtask

   // Long result hold-off while requests keep coming, so the converter backs up.
   task automatic test_result_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_starts++;
      random_expressions(25);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_operator_precedence();
      test_parenthesis_errors();
      test_stack_overflow();
      test_random_streams();
      test_result_backpressure();
      req_tvalid <= 1'b0;
      while (postfix_expected.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (failures == 0) $display("Test completed successfully");
      else $display("Test completed with failures");
      $finish;
   end

endmodule

### sim.f
src/i2p_pkg.sv
src/i2p_ram.sv
src/i2p_dpath.sv
src/i2p_ctrl.sv
src/infix_to_postfix_converter.sv
bench/testbench.sv
